// File: design/assert_macros.svh
// Assertion macros shared by the fixed-point ALU design files.
// Clock and active-low reset are passed explicitly to every macro.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FXA_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
        else $error("fixed-point ALU assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define FXA_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
        else $error("fixed-point ALU assertion failed");

`endif

// File: design/fxa_pkg.sv
// Package for the fixed-point ALU: mode codes, payload and pipeline types.
// Depends on nothing; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package fxa_pkg;

    localparam int FRAC_BITS = 8;
    localparam int WORD_W    = 32;

    localparam logic [WORD_W-1:0] WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
    localparam logic [WORD_W-1:0] WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};
    localparam logic [WORD_W-1:0] ONE_RAW  = WORD_W'(1) << FRAC_BITS;

    typedef enum logic [3:0] {
        MODE_ADD     = 4'd0,
        MODE_SUB     = 4'd1,
        MODE_MUL     = 4'd2,
        MODE_DIV     = 4'd3,
        MODE_GT      = 4'd4,
        MODE_LT      = 4'd5,
        MODE_GE      = 4'd6,
        MODE_LE      = 4'd7,
        MODE_EQ      = 4'd8,
        MODE_NE      = 4'd9,
        MODE_MIN     = 4'd10,
        MODE_MAX     = 4'd11,
        MODE_INC     = 4'd12,
        MODE_DEC     = 4'd13,
        MODE_TOINT   = 4'd14,
        MODE_FROMINT = 4'd15
    } mode_t;

    typedef struct packed {
        mode_t                     mode;
        logic signed [WORD_W-1:0]  operand_a;
        logic signed [WORD_W-1:0]  operand_b;
    } in_t;

    typedef struct packed {
        logic signed [WORD_W-1:0]  result;
        logic                      overflow;
        logic                      divide_by_zero;
    } out_t;

    // Everything one operation carries down the pipeline.
    typedef struct packed {
        mode_t                      mode;
        logic [WORD_W-1:0]          simple_res;
        logic                       simple_ovf;
        logic signed [2*WORD_W-1:0] prod;
        logic                       neg;
        logic                       dbz;
        logic                       dovf;
        logic [WORD_W-1:0]          rem;
        logic [WORD_W-1:0]          nlow;
        logic [WORD_W-1:0]          dvs;
        logic [WORD_W-1:0]          quo;
    } pipe_t;

    typedef struct packed {
        logic [WORD_W-1:0] res;
        logic              ovf;
    } sat_t;

    // Clamp a one-bit-wider signed sum to the word range.
    function automatic sat_t sat_word(input logic signed [WORD_W:0] v);
        sat_t s;
        s.ovf = (v[WORD_W] != v[WORD_W-1]);
        if (s.ovf)
        begin
            s.res = v[WORD_W] ? WORD_MIN : WORD_MAX;
        end
        else
        begin
            s.res = v[WORD_W-1:0];
        end
        return s;
    endfunction

endpackage

`default_nettype wire

// File: design/fxa_front.sv
// First pipeline stage: the simple modes, the product and divider setup.
// Depends on fxa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fxa_front
    import fxa_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  en,
    input  wire logic  in_valid,
    input  wire in_t   in_data,
    output logic       out_valid,
    output pipe_t      out_data
);

    logic              valid_reg;
    pipe_t             data_reg;
    pipe_t             data_next;
    logic signed [WORD_W:0] sum_w;
    sat_t              sat_w;
    logic [WORD_W-1:0] mag_a;
    logic [WORD_W-1:0] mag_b;
    logic [WORD_W-1:0] rem_init;
    logic              fi_fits;
    logic signed [WORD_W-1:0] a;
    logic signed [WORD_W-1:0] b;

    assign a = in_data.operand_a;
    assign b = in_data.operand_b;

    always_comb
    begin
        case (in_data.mode)
            MODE_SUB: sum_w = {a[WORD_W-1], a} - {b[WORD_W-1], b};
            MODE_INC: sum_w = {a[WORD_W-1], a} + (WORD_W+1)'(1);
            MODE_DEC: sum_w = {a[WORD_W-1], a} - (WORD_W+1)'(1);
            default:  sum_w = {a[WORD_W-1], a} + {b[WORD_W-1], b};
        endcase
    end

    assign sat_w = sat_word(sum_w);

    assign mag_a = a[WORD_W-1] ? (WORD_W'(0) - a) : a;
    assign mag_b = b[WORD_W-1] ? (WORD_W'(0) - b) : b;
    // The dividend is |a| shifted up by the fraction; its part above the word starts the remainder.
    assign rem_init = {{(WORD_W-FRAC_BITS){1'b0}}, mag_a[WORD_W-1 -: FRAC_BITS]};
    assign fi_fits = (a[WORD_W-1:WORD_W-1-FRAC_BITS] == '0)
                  || (a[WORD_W-1:WORD_W-1-FRAC_BITS] == '1);

    always_comb
    begin
        data_next            = '0;
        data_next.mode       = in_data.mode;
        data_next.prod       = (2*WORD_W)'(a) * (2*WORD_W)'(b);
        data_next.neg        = a[WORD_W-1] ^ b[WORD_W-1];
        data_next.dbz        = (b == '0);
        data_next.dovf       = (rem_init >= mag_b);
        data_next.rem        = rem_init;
        data_next.nlow       = {mag_a[WORD_W-1-FRAC_BITS:0], {FRAC_BITS{1'b0}}};
        data_next.dvs        = mag_b;
        data_next.quo        = '0;
        case (in_data.mode)
            MODE_ADD, MODE_SUB, MODE_INC, MODE_DEC:
            begin
                data_next.simple_res = sat_w.res;
                data_next.simple_ovf = sat_w.ovf;
            end
            MODE_GT: data_next.simple_res = (a > b)   ? ONE_RAW : '0;
            MODE_LT: data_next.simple_res = (a < b)   ? ONE_RAW : '0;
            MODE_GE: data_next.simple_res = (a >= b)  ? ONE_RAW : '0;
            MODE_LE: data_next.simple_res = (a <= b)  ? ONE_RAW : '0;
            MODE_EQ: data_next.simple_res = (a == b)  ? ONE_RAW : '0;
            MODE_NE: data_next.simple_res = (a != b)  ? ONE_RAW : '0;
            MODE_MIN: data_next.simple_res = (a < b) ? a : b;
            MODE_MAX: data_next.simple_res = (a < b) ? b : a;
            MODE_TOINT: data_next.simple_res = WORD_W'(a >>> FRAC_BITS);
            MODE_FROMINT:
            begin
                if (fi_fits)
                begin
                    data_next.simple_res = {a[WORD_W-1-FRAC_BITS:0], {FRAC_BITS{1'b0}}};
                end
                else
                begin
                    data_next.simple_res = a[WORD_W-1] ? WORD_MIN : WORD_MAX;
                    data_next.simple_ovf = 1'b1;
                end
            end
            default: data_next.simple_res = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

// File: design/fxa_div_stage.sv
// One restoring-division stage: produces one quotient bit per register stage.
// Depends on fxa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fxa_div_stage
    import fxa_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  en,
    input  wire logic  in_valid,
    input  wire pipe_t in_data,
    output logic       out_valid,
    output pipe_t      out_data
);

    logic           valid_reg;
    pipe_t          data_reg;
    pipe_t          data_next;
    logic [WORD_W:0] trial;
    logic [WORD_W:0] diff;
    logic           take;

    // Remainder stays below the divisor, so the shifted value fits one extra bit.
    assign trial = {in_data.rem, in_data.nlow[WORD_W-1]};
    assign diff  = trial - {1'b0, in_data.dvs};
    assign take  = (trial >= {1'b0, in_data.dvs});

    always_comb
    begin
        data_next      = in_data;
        data_next.rem  = take ? diff[WORD_W-1:0] : trial[WORD_W-1:0];
        data_next.nlow = {in_data.nlow[WORD_W-2:0], 1'b0};
        data_next.quo  = {in_data.quo[WORD_W-2:0], take};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

// File: design/fxa_back.sv
// Last pipeline stage: rounding and saturation of products and quotients,
// and the output register. Depends on fxa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fxa_back
    import fxa_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  en,
    input  wire logic  in_valid,
    input  wire pipe_t in_data,
    output logic       out_valid,
    output out_t       out_data
);

    localparam logic [2*WORD_W-1:0] HALF     = (2*WORD_W)'(1) << (FRAC_BITS - 1);
    localparam logic [2*WORD_W-1:0] POS_LIM  = (2*WORD_W)'(WORD_MAX);
    localparam logic [2*WORD_W-1:0] NEG_LIM  = (2*WORD_W)'(WORD_MIN);

    logic              valid_reg;
    out_t              data_reg;
    out_t              data_next;
    logic [2*WORD_W-1:0] mag_p;
    logic [2*WORD_W-1:0] mag_r;
    logic              p_neg;
    logic              round_up;
    logic [2*WORD_W-1:0] q_r;
    logic [2*WORD_W-1:0] mag_sel;
    logic              neg_sel;
    logic              sat_sel;

    assign p_neg = in_data.prod[2*WORD_W-1];
    assign mag_p = p_neg ? ((2*WORD_W)'(0) - in_data.prod) : in_data.prod;
    assign mag_r = (mag_p + HALF) >> FRAC_BITS;

    // Round to nearest, ties away from zero: bump when twice the remainder reaches the divisor.
    assign round_up = ({in_data.rem, 1'b0} >= {1'b0, in_data.dvs});
    assign q_r = (2*WORD_W)'(in_data.quo) + (2*WORD_W)'(round_up);

    assign neg_sel = (in_data.mode == MODE_MUL) ? p_neg : in_data.neg;
    assign mag_sel = (in_data.mode == MODE_MUL) ? mag_r : q_r;
    assign sat_sel = ((in_data.mode == MODE_DIV) && in_data.dovf)
                  || (neg_sel ? (mag_sel > NEG_LIM) : (mag_sel > POS_LIM));

    always_comb
    begin
        data_next = '0;
        case (in_data.mode)
            MODE_MUL, MODE_DIV:
            begin
                if ((in_data.mode == MODE_DIV) && in_data.dbz)
                begin
                    data_next.divide_by_zero = 1'b1;
                end
                else if (sat_sel)
                begin
                    data_next.result   = neg_sel ? WORD_MIN : WORD_MAX;
                    data_next.overflow = 1'b1;
                end
                else
                begin
                    data_next.result = neg_sel ? (WORD_W'(0) - mag_sel[WORD_W-1:0])
                                               : mag_sel[WORD_W-1:0];
                end
            end
            default:
            begin
                data_next.result   = in_data.simple_res;
                data_next.overflow = in_data.simple_ovf;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

// File: design/fixed_point_alu_unit.sv
// Signed fixed-point ALU with FRAC_BITS fractional bits, fully pipelined.
// Depends on fxa_pkg, fxa_front, fxa_div_stage, fxa_back and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

// Takes one operation per cycle while the output is not stalled and delivers
// the results in order. Each operation passes the front stage, a chain of
// WORD_W restoring divider stages that each settle one quotient bit, and the
// back stage; every mode travels the same path so results never reorder.
// A stalled output freezes the whole pipeline, and the input is ready whenever
// the output register is empty or is being taken in the same cycle.
`include "assert_macros.svh"

module fixed_point_alu_unit
    import fxa_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_ready,
    input  wire in_t  in_data,
    output logic      out_valid,
    input  wire logic out_ready,
    output out_t      out_data
);

    logic  en;
    logic  stg_valid [WORD_W+1];
    pipe_t stg_data  [WORD_W+1];

    assign en       = !out_valid || out_ready;
    assign in_ready = en;

    fxa_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_valid),
        .in_data   (in_data),
        .out_valid (stg_valid[0]),
        .out_data  (stg_data[0])
    );

    for (genvar i = 0; i < WORD_W; i++)
    begin : g_div
        fxa_div_stage u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (stg_valid[i]),
            .in_data   (stg_data[i]),
            .out_valid (stg_valid[i+1]),
            .out_data  (stg_data[i+1])
        );
    end

    fxa_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (stg_valid[WORD_W]),
        .in_data   (stg_data[WORD_W]),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

    `FXA_ASSERT_IMP(a_dbz_zero, clk, rst_n, out_valid && out_data.divide_by_zero, (out_data.result == '0) && !out_data.overflow)
    `FXA_ASSERT_IMP(a_ovf_bound, clk, rst_n, out_valid && out_data.overflow, (out_data.result == WORD_MAX) || (out_data.result == WORD_MIN))
    `FXA_ASSERT_NXT(a_stall_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(stg_valid[WORD_W]))

endmodule

`default_nettype wire
